[rtl/core/rc4_pkg.sv]
// Shared types, constants and the microprogram of the RC4 cipher engine.
// No dependencies; used by rc4_seq and rc4_stream_cipher_unit.
package rc4_pkg;

	localparam int BYTE_W            = 8;
	localparam int KEY_LEN_W         = 9;
	localparam int DEF_MAX_KEY_BYTES = 256;
	localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 9'd16;
	localparam logic [BYTE_W-1:0]    LAST_BYTE     = 8'hFF;

	// item kinds carried in tuser
	localparam logic CMD_KEY  = 1'b0;
	localparam logic CMD_DATA = 1'b1;

	localparam int STEP_W = 4;

	typedef enum logic [STEP_W-1:0] {
		ST_IDLE = 4'd0,
		ST_INIT = 4'd1,
		ST_K0   = 4'd2,
		ST_K1   = 4'd3,
		ST_K2   = 4'd4,
		ST_K3   = 4'd5,
		ST_KE   = 4'd6,
		ST_P0   = 4'd7,
		ST_P1   = 4'd8,
		ST_P2   = 4'd9,
		ST_P3   = 4'd10
	} step_t;

	typedef enum logic [1:0] {I_HOLD, I_INC, I_ACC_INC, I_CLR} i_op_t;
	typedef enum logic [1:0] {J_HOLD, J_CLR, J_KSA, J_PRGA} j_op_t;
	typedef enum logic [1:0] {N_HOLD, N_CLR, N_INC} n_op_t;
	typedef enum logic [1:0] {KP_HOLD, KP_CLR, KP_INC} kp_op_t;
	typedef enum logic [2:0] {RA_I_NEXT, RA_N, RA_N_NEXT, RA_J, RA_T} ra_sel_t;
	typedef enum logic [1:0] {WA_N, WA_I, WA_J} wa_sel_t;
	typedef enum logic [1:0] {WD_N, WD_RD, WD_SI} wd_sel_t;
	typedef enum logic [2:0] {BR_NEXT, BR_GOTO, BR_LOOP_N, BR_DISPATCH, BR_WAIT_OUT} br_t;

	typedef struct packed {
		logic     in_ready;
		i_op_t    i_op;
		j_op_t    j_op;
		n_op_t    n_op;
		kp_op_t   kp_op;
		logic     si_ld;
		logic     t_ld;
		logic     s_re;
		ra_sel_t  ra_sel;
		logic     s_we;
		wa_sel_t  wa_sel;
		wd_sel_t  wd_sel;
		logic     out_ld;
		br_t      br;
		step_t    target;
	} ctrl_t;

	typedef struct packed {
		logic in_acc;
		logic cmd;
		logic som;
		logic n_last;
		logic out_free;
	} status_t;

	localparam ctrl_t UC_NOP = '{
		in_ready: 1'b0, i_op: I_HOLD, j_op: J_HOLD, n_op: N_HOLD, kp_op: KP_HOLD,
		si_ld: 1'b0, t_ld: 1'b0, s_re: 1'b0, ra_sel: RA_N, s_we: 1'b0,
		wa_sel: WA_N, wd_sel: WD_N, out_ld: 1'b0, br: BR_GOTO, target: ST_IDLE
	};

	// control store: one word per step
	function automatic ctrl_t ucode(input step_t step);
		ctrl_t w;
		w = UC_NOP;
		unique case (step)
			ST_IDLE: begin
				w.in_ready = 1'b1;
				w.i_op     = I_ACC_INC;
				w.n_op     = N_CLR;
				w.s_re     = 1'b1;
				w.ra_sel   = RA_I_NEXT;
				w.br       = BR_DISPATCH;
				w.target   = ST_P1;
			end
			ST_INIT: begin
				w.s_we   = 1'b1;
				w.wa_sel = WA_N;
				w.wd_sel = WD_N;
				w.n_op   = N_INC;
				w.j_op   = J_CLR;
				w.kp_op  = KP_CLR;
				w.br     = BR_LOOP_N;
				w.target = ST_INIT;
			end
			ST_K0: begin
				w.s_re   = 1'b1;
				w.ra_sel = RA_N;
				w.br     = BR_NEXT;
			end
			ST_K1: begin
				w.j_op   = J_KSA;
				w.si_ld  = 1'b1;
				w.s_re   = 1'b1;
				w.ra_sel = RA_J;
				w.kp_op  = KP_INC;
				w.br     = BR_NEXT;
			end
			ST_K2: begin
				w.s_we   = 1'b1;
				w.wa_sel = WA_N;
				w.wd_sel = WD_RD;
				w.br     = BR_NEXT;
			end
			ST_K3: begin
				w.s_we   = 1'b1;
				w.wa_sel = WA_J;
				w.wd_sel = WD_SI;
				w.s_re   = 1'b1;
				w.ra_sel = RA_N_NEXT;
				w.n_op   = N_INC;
				w.br     = BR_LOOP_N;
				w.target = ST_K1;
			end
			ST_KE: begin
				w.i_op = I_CLR;
				w.j_op = J_CLR;
				w.br   = BR_NEXT;
			end
			ST_P0: begin
				w.i_op   = I_INC;
				w.s_re   = 1'b1;
				w.ra_sel = RA_I_NEXT;
				w.br     = BR_NEXT;
			end
			ST_P1: begin
				w.j_op   = J_PRGA;
				w.si_ld  = 1'b1;
				w.s_re   = 1'b1;
				w.ra_sel = RA_J;
				w.br     = BR_NEXT;
			end
			ST_P2: begin
				w.s_we   = 1'b1;
				w.wa_sel = WA_I;
				w.wd_sel = WD_RD;
				w.t_ld   = 1'b1;
				w.s_re   = 1'b1;
				w.ra_sel = RA_T;
				w.br     = BR_NEXT;
			end
			ST_P3: begin
				w.s_we   = 1'b1;
				w.wa_sel = WA_J;
				w.wd_sel = WD_SI;
				w.out_ld = 1'b1;
				w.br     = BR_WAIT_OUT;
				w.target = ST_IDLE;
			end
			default: begin
				w.br     = BR_GOTO;
				w.target = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

[rtl/core/rc4_stream_cipher_unit.sv]
// RC4 cipher engine top level: handshakes, key store, permutation memory, datapath.
// Depends on rc4_pkg and rc4_seq.
//
// Usage: items arrive on the s_ channel. tuser[0] is the kind: key items write
// tdata[15:8] into the key store at tdata[7:0] (indices at or above MAX_KEY_BYTES
// are dropped) and produce nothing. Data items carry a byte in tdata[15:8] and
// return exactly one item on the m_ channel: that byte XOR the next keystream
// byte. A data item with tuser[1] set (start of message) first rebuilds the
// permutation from the first key_length key bytes and clears i and j.
// key_length is written through cfg_wr_en / cfg_wr_data while the engine is idle;
// 0 acts as 1 and values above MAX_KEY_BYTES saturate.
// Steps: a key item is taken in the idle step. A data item is accepted in the idle
// step (read of S[i]); then P1 reads S[j], P2 writes S[i] and reads S[t], and P3
// writes S[j] and loads the result, as the one-read one-write permutation memory
// requires; only then does the engine take the next item. A start-of-message item
// first runs the identity fill (INIT), the key schedule (K0, K1-K3 per entry), KE, P0.
// The output register holds one result; the next item is accepted while it waits,
// and the sequencer holds in its last step only if that register is still full.
// Reset clears the indices, the key length (to 16) and the output valid; the key
// store and permutation are not cleared, so a message must start with a key schedule.
module rc4_stream_cipher_unit import rc4_pkg::*; #(
	parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [KEY_LEN_W-1:0] cfg_wr_data,   // key_length
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,       // [7:0] key_index, [15:8] value
	input  logic [1:0]           s_tuser,       // [0] cmd, [1] start_of_message
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata        // [7:0] data_out
);

	localparam int KIDX_W = $clog2(MAX_KEY_BYTES);

	ctrl_t   ctrl;
	status_t sts;

	// configuration
	logic [KEY_LEN_W-1:0] key_len_q;
	logic [KEY_LEN_W-1:0] key_last;

	// datapath registers
	logic [BYTE_W-1:0] i_q, j_q, n_q;
	logic [BYTE_W-1:0] si_q, t_q, val_q, rd_q, key_rd_q, out_q;
	logic [KIDX_W-1:0] kp_q;
	logic              m_tvalid_q;

	logic [BYTE_W-1:0] j_d, t_d, raddr, waddr, wdata, ks;
	logic              in_acc, out_free, key_we;
	logic              in_cmd, in_som;
	logic [BYTE_W-1:0] in_key_index, in_value;

	logic [BYTE_W-1:0] sbox_mem [256];
	logic [BYTE_W-1:0] key_mem  [MAX_KEY_BYTES];

	assign in_cmd       = s_tuser[0];
	assign in_som       = s_tuser[1];
	assign in_key_index = s_tdata[7:0];
	assign in_value     = s_tdata[15:8];

	assign s_tready = ctrl.in_ready;
	assign in_acc   = s_tvalid && ctrl.in_ready;
	assign out_free = !m_tvalid_q || m_tready;
	assign key_we   = in_acc && in_cmd == CMD_KEY
		&& {1'b0, in_key_index} < KEY_LEN_W'(MAX_KEY_BYTES);

	assign sts = '{in_acc: in_acc, cmd: in_cmd, som: in_som,
		n_last: n_q == LAST_BYTE, out_free: out_free};

	rc4_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.sts   (sts),
		.ctrl  (ctrl)
	);

	// last key index used by the schedule: clamp 0 up to 1, saturate at the store size
	always_comb begin
		if (key_len_q == '0) begin
			key_last = '0;
		end else if (key_len_q > KEY_LEN_W'(MAX_KEY_BYTES)) begin
			key_last = KEY_LEN_W'(MAX_KEY_BYTES - 1);
		end else begin
			key_last = key_len_q - KEY_LEN_W'(1);
		end
	end

	always_comb begin
		case (ctrl.j_op)
			J_CLR:   j_d = '0;
			J_KSA:   j_d = j_q + rd_q + key_rd_q;
			J_PRGA:  j_d = j_q + rd_q;
			default: j_d = j_q;
		endcase
	end

	assign t_d = si_q + rd_q;
	// S[t] is read before S[j] is written back: patch that case
	assign ks  = (t_q == j_q) ? si_q : rd_q;

	always_comb begin
		case (ctrl.ra_sel)
			RA_I_NEXT: raddr = i_q + BYTE_W'(1);
			RA_N_NEXT: raddr = n_q + BYTE_W'(1);
			RA_J:      raddr = j_d;
			RA_T:      raddr = t_d;
			default:   raddr = n_q;
		endcase
		case (ctrl.wa_sel)
			WA_I:    waddr = i_q;
			WA_J:    waddr = j_q;
			default: waddr = n_q;
		endcase
		case (ctrl.wd_sel)
			WD_RD:   wdata = rd_q;
			WD_SI:   wdata = si_q;
			default: wdata = n_q;
		endcase
	end

	// permutation memory, write-first on an address clash
	always_ff @(posedge clk) begin
		if (ctrl.s_we) begin
			sbox_mem[waddr] <= wdata;
		end
		if (ctrl.s_re) begin
			if (ctrl.s_we && waddr == raddr) begin
				rd_q <= wdata;
			end else begin
				rd_q <= sbox_mem[raddr];
			end
		end
	end

	// key store
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[in_key_index[KIDX_W-1:0]] <= in_value;
		end
		key_rd_q <= key_mem[kp_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q  <= KEY_LEN_RESET;
			i_q        <= '0;
			j_q        <= '0;
			n_q        <= '0;
			kp_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				key_len_q <= cfg_wr_data;
			end
			case (ctrl.i_op)
				I_INC:     i_q <= i_q + BYTE_W'(1);
				I_CLR:     i_q <= '0;
				I_ACC_INC: begin
					if (in_acc && in_cmd == CMD_DATA) begin
						i_q <= i_q + BYTE_W'(1);
					end
				end
				default:   i_q <= i_q;
			endcase
			j_q <= j_d;
			case (ctrl.n_op)
				N_CLR:   n_q <= '0;
				N_INC:   n_q <= n_q + BYTE_W'(1);
				default: n_q <= n_q;
			endcase
			case (ctrl.kp_op)
				KP_CLR:  kp_q <= '0;
				KP_INC: begin
					if (KEY_LEN_W'(kp_q) == key_last) begin
						kp_q <= '0;
					end else begin
						kp_q <= kp_q + KIDX_W'(1);
					end
				end
				default: kp_q <= kp_q;
			endcase
			if (ctrl.out_ld && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			val_q <= in_value;
		end
		if (ctrl.si_ld) begin
			si_q <= rd_q;
		end
		if (ctrl.t_ld) begin
			t_q <= t_d;
		end
		if (ctrl.out_ld && out_free) begin
			out_q <= val_q ^ ks;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

endmodule

[rtl/core/rc4_seq.sv]
// Microsequencer: step counter, control store lookup and branch logic.
// Depends on rc4_pkg.
module rc4_seq import rc4_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t sts,
	output ctrl_t   ctrl
);

	step_t step_q;
	step_t step_d;
	step_t step_inc;

	assign step_inc = step_t'(step_q + STEP_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		ctrl   = ucode(step_q);
		step_d = step_q;
		unique case (ctrl.br)
			BR_NEXT: step_d = step_inc;
			BR_GOTO: step_d = ctrl.target;
			BR_LOOP_N: begin
				step_d = sts.n_last ? step_inc : ctrl.target;
			end
			BR_DISPATCH: begin
				if (sts.in_acc && sts.cmd == CMD_DATA) begin
					step_d = sts.som ? ST_INIT : ctrl.target;
				end
			end
			BR_WAIT_OUT: begin
				if (sts.out_free) begin
					step_d = ctrl.target;
				end
			end
			default: step_d = ST_IDLE;
		endcase
	end

endmodule

[test/rc4_stream_cipher_unit_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for rc4_stream_cipher_unit: follows config writes and s_/m_ items,
// keeps its own keystream state and checks every ciphered byte. Depends on rc4_pkg.
module rc4_stream_cipher_unit_checker import rc4_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [KEY_LEN_W-1:0] cfg_wr_data,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [15:0]          s_tdata,     // [7:0] key_index, [15:8] value
	input  logic [1:0]           s_tuser,     // [0] cmd, [1] start_of_message
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [7:0]           m_tdata,     // [7:0] data_out
	input  logic                 run_done,
	output int                   fail_count,
	output int                   pending,
	output int                   checked
);

	localparam int KEY_SLOTS  = DEF_MAX_KEY_BYTES;
	localparam int MAX_PRINTS = 40;

	logic [BYTE_W-1:0]    perm [256];
	logic [BYTE_W-1:0]    key_bytes [KEY_SLOTS];
	logic [BYTE_W-1:0]    ptr_i;
	logic [BYTE_W-1:0]    ptr_j;
	logic [KEY_LEN_W-1:0] key_len;
	logic [BYTE_W-1:0]    expected_bytes [$];

	initial begin
		fail_count = 0;
		pending    = 0;
		checked    = 0;
	end

	task automatic report_mismatch(input string what);
		if (fail_count < MAX_PRINTS)
			$display("%0t ns: MISMATCH %s", $time, what);
		fail_count++;
	endtask

	// identity fill, then mix with the key bytes repeated over the effective length
	task automatic run_key_schedule();
		int unsigned       span;
		logic [BYTE_W-1:0] acc;
		logic [BYTE_W-1:0] tmp;
		span = (key_len == 0) ? 1 : ((key_len > KEY_SLOTS) ? KEY_SLOTS : key_len);
		for (int n = 0; n < 256; n++)
			perm[n] = BYTE_W'(n);
		acc = '0;
		for (int n = 0; n < 256; n++) begin
			acc     = acc + perm[n] + key_bytes[n % span];
			tmp     = perm[n];
			perm[n] = perm[acc];
			perm[acc] = tmp;
		end
		ptr_i = '0;
		ptr_j = '0;
	endtask

	// one keystream step: advance, swap, xor
	task automatic cipher_byte(input logic [BYTE_W-1:0] din, output logic [BYTE_W-1:0] dout);
		logic [BYTE_W-1:0] tmp;
		ptr_i       = ptr_i + 8'd1;
		ptr_j       = ptr_j + perm[ptr_i];
		tmp         = perm[ptr_i];
		perm[ptr_i] = perm[ptr_j];
		perm[ptr_j] = tmp;
		dout = din ^ perm[BYTE_W'(perm[ptr_i] + perm[ptr_j])];
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		logic [BYTE_W-1:0] want;
		if (!arst_n) begin
			key_len = KEY_LEN_RESET;
			ptr_i   = '0;
			ptr_j   = '0;
			expected_bytes.delete();
			pending <= 0;
		end else begin
			// results first: an item accepted this edge cannot have its result yet
			if (m_tvalid && m_tready) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("output item 0x%02h with none expected", m_tdata));
				end else begin
					want = expected_bytes.pop_front();
					if (m_tdata !== want)
						report_mismatch($sformatf("byte %0d: got 0x%02h, expected 0x%02h",
							checked, m_tdata, want));
					checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == CMD_KEY) begin
					if (int'(s_tdata[7:0]) < KEY_SLOTS)
						key_bytes[s_tdata[7:0]] = s_tdata[15:8];
				end else begin
					if (s_tuser[1])
						run_key_schedule();
					cipher_byte(s_tdata[15:8], want);
					expected_bytes.push_back(want);
				end
			end
			if (cfg_wr_en)
				key_len = cfg_wr_data;
			pending <= expected_bytes.size();
		end
	end

	always @(posedge run_done) begin
		if (expected_bytes.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_bytes.size()));
	end

endmodule

[test/rc4_stream_cipher_unit_tb.sv]
`timescale 1ns / 1ps
// Testbench top for rc4_stream_cipher_unit: reset, key/data item stimulus, key length
// settings and the verdict. Depends on rc4_pkg, the block and rc4_stream_cipher_unit_checker.
module rc4_stream_cipher_unit_tb;
	import rc4_pkg::*;

	localparam int TARGET_ITEMS = 1850;
	// a start-of-message item keeps the bus quiet during its key schedule; add the longest
	// sender gap and receiver stall, then several times over
	localparam int STALL_LIMIT  = 8000;
	localparam int KEY_SLOTS    = DEF_MAX_KEY_BYTES;
	localparam int PLAN_LEN     = 8;
	// fixed key lengths tried first: reset value, full store, saturating, tiny, zero, then 2 and 255
	localparam logic [KEY_LEN_W-1:0] LEN_PLAN [PLAN_LEN] =
		'{9'd16, 9'd256, 9'd511, 9'd257, 9'd1, 9'd0, 9'd2, 9'd255};

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 cfg_wr_en   = 1'b0;
	logic [KEY_LEN_W-1:0] cfg_wr_data = '0;
	logic                 s_tvalid    = 1'b0;
	logic                 s_tready;
	logic [15:0]          s_tdata     = '0;   // [7:0] key_index, [15:8] value
	logic [1:0]           s_tuser     = '0;   // [0] cmd, [1] start_of_message
	logic                 m_tvalid;
	logic                 m_tready    = 1'b0;
	logic [7:0]           m_tdata;            // [7:0] data_out
	logic                 run_done    = 1'b0;

	int fail_count;
	int pending;
	int checked;

	bit                   calm = 1'b0;        // no gaps and no stalls while set
	bit                   key_written [KEY_SLOTS];
	bit                   keyed = 1'b0;       // a key schedule has been requested
	logic [KEY_LEN_W-1:0] cur_len = KEY_LEN_RESET;
	int items_sent   = 0;
	int key_items    = 0;
	int data_items   = 0;
	int messages     = 0;
	int len_settings = 0;
	int idle_cycles  = 0;

	rc4_stream_cipher_unit #(
		.MAX_KEY_BYTES(DEF_MAX_KEY_BYTES)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	rc4_stream_cipher_unit_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.run_done   (run_done),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog: any cycle with no item moving on either side counts towards the limit
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= STALL_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
			$display("rc4_stream_cipher_unit regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// mostly no gap, some short ones, the odd long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// receiver: ready most cycles, stalls of the same spread otherwise
	initial begin : receiver
		int n;
		forever begin
			@(posedge clk);
			if (calm || $urandom_range(0, 3) != 0) begin
				m_tready <= 1'b1;
			end else begin
				n = pick_gap();
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	// tvalid stays high across back-to-back items; this task only lowers it ahead of a gap
	task automatic send_item(input logic cmd, input logic [7:0] idx, input logic [7:0] val,
			input logic som);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {val, idx};
		s_tuser  <= {som, cmd};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// start_of_message is meaningless on a key item, so it is left random there
	task automatic write_key(input logic [7:0] idx, input logic [7:0] val);
		send_item(CMD_KEY, idx, val, 1'($urandom_range(0, 1)));
		key_written[idx] = 1'b1;
		key_items++;
	endtask

	task automatic send_data(input logic [7:0] val, input logic som);
		send_item(CMD_DATA, 8'($urandom), val, som);
		data_items++;
		if (som) begin
			keyed = 1'b1;
			messages++;
		end
	endtask

	function automatic int eff_len(input logic [KEY_LEN_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > KEY_SLOTS)
			return KEY_SLOTS;
		return v;
	endfunction

	// the key schedule must never read a key byte that was never written
	task automatic start_message(input logic [7:0] val);
		for (int k = 0; k < eff_len(cur_len); k++)
			if (!key_written[k])
				write_key(8'(k), 8'($urandom));
		send_data(val, 1'b1);
	endtask

	// register writes only once the engine has drained and settled
	task automatic set_key_length(input logic [KEY_LEN_W-1:0] v);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_len = v;
		len_settings++;
	endtask

	function automatic int pick_msg_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 12);
		if (r < 95)
			return $urandom_range(13, 48);
		return $urandom_range(100, 200);
	endfunction

	// a message is a keyed opener plus data; a continued one skips the opener
	task automatic run_message(input bit fresh, input int nbytes);
		if (fresh)
			start_message(8'($urandom));
		for (int b = 0; b < nbytes; b++) begin
			// stray key write mid-message: must not disturb the running keystream
			if ($urandom_range(0, 19) == 0)
				write_key(8'($urandom), 8'($urandom));
			send_data(8'($urandom), 1'b0);
		end
	endtask

	initial begin : stimulus
		int  phase;
		int  n_msgs;
		bit  fresh;
		logic [KEY_LEN_W-1:0] v;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: key bytes with extreme values and the top index, reset key length
		write_key(8'd0, 8'h00);
		write_key(8'd1, 8'hFF);
		for (int k = 2; k < 16; k++)
			write_key(8'(k), 8'($urandom));
		write_key(8'hFF, 8'hFF);
		start_message(8'h00);
		send_data(8'hFF, 1'b0);
		send_data(8'h5A, 1'b0);
		// zero key length behaves as one byte
		set_key_length('0);
		start_message(8'hFF);
		send_data(8'h00, 1'b0);
		set_key_length(9'd1);
		start_message(8'h3C);

		// random phases: new key length each phase, a few messages each
		phase = 0;
		while (items_sent < TARGET_ITEMS) begin
			if (phase < PLAN_LEN)
				v = LEN_PLAN[phase];
			else if ($urandom_range(0, 3) != 0)
				v = KEY_LEN_W'($urandom_range(1, 256));
			else
				v = KEY_LEN_W'($urandom_range(0, 511));
			set_key_length(v);
			calm   = ($urandom_range(0, 4) == 0);
			n_msgs = $urandom_range(1, 4);
			for (int m = 0; m < n_msgs; m++) begin
				repeat ($urandom_range(0, 6)) begin
					if ($urandom_range(0, 1) != 0)
						write_key(8'($urandom_range(0, eff_len(cur_len) - 1)), 8'($urandom));
					else
						write_key(8'($urandom), 8'($urandom));
				end
				// now and then carry on the old keystream across a length change
				fresh = !(keyed && m == 0 && $urandom_range(0, 3) == 0);
				run_message(fresh, pick_msg_len());
			end
			phase++;
		end

		// drain, let the engine settle, then close out the scoreboard
		calm = 1'b0;
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (16) @(posedge clk);
		run_done <= 1'b1;
		repeat (2) @(posedge clk);

		$display("run covered %0d items: %0d key writes, %0d data bytes in %0d keyed messages",
			items_sent, key_items, data_items, messages);
		$display("%0d key length settings, %0d ciphered bytes compared", len_settings, checked);
		if (fail_count == 0)
			$display("rc4_stream_cipher_unit regression: pass");
		else
			$display("rc4_stream_cipher_unit regression: fail");
		$finish;
	end

endmodule
